// ----- sv/swr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum waterfall row store package
// Shared widths, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int unsigned DEF_ROWS = 256;
  localparam int unsigned DEF_COLS = 1024;

  localparam int unsigned FREQ_W   = 33;
  localparam int unsigned BIN_W    = 30;
  localparam int unsigned PWR_W    = 16;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 2'd1;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_PAST_COLS   = 3'd1;
  localparam logic [ST_W-1:0] ST_BELOW_START = 3'd2;
  localparam logic [ST_W-1:0] ST_WIDTH_ZERO  = 3'd3;
  localparam logic [ST_W-1:0] ST_READ_RANGE  = 3'd4;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_WIDTH_ZERO,
    KIND_READ,
    KIND_READ_BAD
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [FREQ_W-1:0]        freq;
    logic signed [PWR_W-1:0]  power;
    logic                     first;
    logic                     last;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ----- sv/swr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waterfall front end
// Accepts words, classifies them and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module swr_front import swr_pkg::*; #(
  parameter int unsigned ROWS = DEF_ROWS,
  parameter int unsigned COLS = DEF_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    func_i,
  input  logic [FREQ_W-1:0]       freq_i,
  input  logic signed [PWR_W-1:0] power_i,
  input  logic                    first_of_row_i,
  input  logic                    last_of_row_i,
  input  logic [IDX_W-1:0]        read_row_i,
  input  logic [IDX_W-1:0]        read_col_i,
  input  logic                    bin_zero_i,
  input  back_stat_t              back_i,
  output cmd_t                    cmd_o,
  output logic                    cmd_valid_o,
  input  logic                    cmd_pop_i
);

  cmd_t       q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       accept;
  cmd_t       cmd_new;

  assign full        = (cnt_q == 2'd2) || back_i.clearing;
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rptr_q];

  always_comb begin
    cmd_new.freq  = freq_i;
    cmd_new.power = power_i;
    cmd_new.first = first_of_row_i;
    cmd_new.last  = last_of_row_i;
    cmd_new.row   = read_row_i;
    cmd_new.col   = read_col_i;
    if (func_i) begin
      if (({1'b0, read_col_i} >= (IDX_W+1)'(COLS)) ||
          ({1'b0, read_row_i} >= (IDX_W+1)'(ROWS))) begin
        cmd_new.kind = KIND_READ_BAD;
      end else begin
        cmd_new.kind = KIND_READ;
      end
    end else if (bin_zero_i) begin
      cmd_new.kind = KIND_WIDTH_ZERO;
    end else begin
      cmd_new.kind = KIND_WRITE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, cmd_pop_i};
    end
  end

endmodule

// ----- sv/swr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waterfall back end
// Sequencer over the cell memory: clearing, row fill, column divide, access.
// ----------------------------------------------------------------------------
module swr_back import swr_pkg::*; #(
  parameter int unsigned ROWS = DEF_ROWS,
  parameter int unsigned COLS = DEF_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [BIN_W-1:0]        bin_width_i,
  input  logic signed [PWR_W-1:0] fill_value_i,
  input  cmd_t                    cmd_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_pop_o,
  output back_stat_t              stat_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [PWR_W-1:0] read_value_o,
  output logic [ST_W-1:0]         status_o
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned KW    = $clog2(CW + 1);
  localparam int unsigned XW    = (BIN_W + CW > FREQ_W) ? BIN_W + CW : FREQ_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FILL, S_CHECK, S_LIMIT, S_DIV, S_STORE, S_RDONE, S_FINISH
  } state_e;

  state_e            state_q;
  cmd_t              cur_q;
  logic [RW-1:0]     wri_q;
  logic [FREQ_W-1:0] start_q;
  logic [AW-1:0]     clr_q;
  logic [CW-1:0]     fcnt_q;
  logic [XW-1:0]     rem_q;
  logic [CW-1:0]     quo_q;
  logic [KW-1:0]     bit_q;
  logic [ST_W-1:0]   status_q;

  logic signed [PWR_W-1:0] mem [DEPTH];
  logic signed [PWR_W-1:0] rdata_q;

  logic signed [PWR_W-1:0] rv_q [2];
  logic [ST_W-1:0]         rs_q [2];
  logic                    rw_q, rr_q;
  logic [1:0]              rcnt_q;

  logic                    we;
  logic [AW-1:0]           waddr, raddr, wbase;
  logic signed [PWR_W-1:0] wdata;
  logic                    res_push, res_pop;
  logic signed [PWR_W-1:0] res_val;
  logic [ST_W-1:0]         res_st;
  logic [RW:0]             rsum, rrow, wnext;
  logic [XW-1:0]           limit, dv;
  logic                    ge;

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign empty        = (rcnt_q == 2'd0);
  assign res_pop      = pop && !empty;
  assign read_value_o = rv_q[rr_q];
  assign status_o     = rs_q[rr_q];
  assign cmd_pop_o    = (state_q == S_IDLE) && cmd_valid_i && (rcnt_q != 2'd2);

  // Address of a read: ring rotation by the write index.
  assign rsum  = {1'b0, wri_q} + {1'b0, cmd_i.row[RW-1:0]};
  assign rrow  = (rsum >= (RW+1)'(ROWS)) ? rsum - (RW+1)'(ROWS) : rsum;
  assign raddr = AW'(rrow) * AW'(COLS) + AW'(cmd_i.col[CW-1:0]);
  assign wbase = AW'(wri_q) * AW'(COLS);
  assign wnext = {1'b0, wri_q} + (RW+1)'(1);

  assign limit = XW'(bin_width_i) * XW'(COLS);
  assign dv    = XW'(bin_width_i) << bit_q;
  assign ge    = (rem_q >= dv);

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = wbase + AW'(fcnt_q);
        wdata = fill_value_i;
      end
      S_STORE: begin
        we    = 1'b1;
        waddr = wbase + AW'(quo_q);
        wdata = cur_q.power;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_push = 1'b0;
    res_val  = '0;
    res_st   = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop_o && cmd_i.kind == KIND_READ_BAD) begin
          res_push = 1'b1;
          res_st   = ST_READ_RANGE;
        end else if (cmd_pop_o && cmd_i.kind == KIND_WIDTH_ZERO) begin
          res_push = 1'b1;
          res_st   = ST_WIDTH_ZERO;
        end
      end
      S_RDONE: begin
        res_push = 1'b1;
        res_val  = rdata_q;
        res_st   = ST_OK;
      end
      S_FINISH: begin
        res_push = 1'b1;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rv_q[rw_q] <= res_val;
      rs_q[rw_q] <= res_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cur_q    <= '0;
      wri_q    <= '0;
      start_q  <= '0;
      clr_q    <= '0;
      fcnt_q   <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      bit_q    <= '0;
      status_q <= ST_OK;
      rw_q     <= 1'b0;
      rr_q     <= 1'b0;
      rcnt_q   <= 2'd0;
    end else begin
      if (res_push) begin
        rw_q <= ~rw_q;
      end
      if (res_pop) begin
        rr_q <= ~rr_q;
      end
      rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, res_pop};

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop_o) begin
            cur_q    <= cmd_i;
            status_q <= ST_OK;
            fcnt_q   <= '0;
            unique case (cmd_i.kind)
              KIND_READ: begin
                state_q <= S_RDONE;
              end
              KIND_WRITE: begin
                if (cmd_i.first) begin
                  start_q <= cmd_i.freq;
                  state_q <= S_FILL;
                end else begin
                  state_q <= S_CHECK;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_FILL: begin
          fcnt_q <= fcnt_q + CW'(1);
          if (fcnt_q == CW'(COLS - 1)) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cur_q.freq < start_q) begin
            status_q <= ST_BELOW_START;
            state_q  <= S_FINISH;
          end else begin
            rem_q   <= XW'(cur_q.freq - start_q);
            state_q <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          if (rem_q >= limit) begin
            status_q <= ST_PAST_COLS;
            state_q  <= S_FINISH;
          end else begin
            quo_q   <= '0;
            bit_q   <= KW'(CW - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dv;
          end
          quo_q <= (quo_q << 1) | CW'(ge);
          bit_q <= bit_q - KW'(1);
          if (bit_q == '0) begin
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          state_q <= S_FINISH;
        end
        S_RDONE: begin
          state_q <= S_IDLE;
        end
        S_FINISH: begin
          if (cur_q.last) begin
            wri_q <= (wnext == (RW+1)'(ROWS)) ? '0 : wnext[RW-1:0];
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/spectrum_waterfall_row_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum waterfall row store
// Ring of ROWS spectrum rows of COLS signed Q8.8 cells, written per sample.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ROWS*COLS cells,
// zeroing the cell memory one entry per cycle; full stays high meanwhile,
// while configuration writes are taken as usual. Each word then yields
// exactly one result word. A read sends its address from the idle state and
// returns the registered memory read from the read-done state; a read out of
// range or a write while the bin width is zero is answered from the idle
// state. A write sample that lands in a column passes the check, limit,
// divide and store states, the restoring divider producing one quotient bit
// per cycle over CW bits, CW being the column index width (ten at the
// defaults); a sample below the row start ends after the check, one past the
// last column after the limit test. The first sample of a row adds a fill
// sweep over COLS cells through the single memory write port. A two-entry
// command queue and result queue let both sides stall independently.
module spectrum_waterfall_row_store_unit import swr_pkg::*; #(
  parameter int unsigned ROWS = DEF_ROWS,
  parameter int unsigned COLS = DEF_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic                    func_i,
  input  logic [FREQ_W-1:0]       freq_i,
  input  logic signed [PWR_W-1:0] power_i,
  input  logic                    first_of_row_i,
  input  logic                    last_of_row_i,
  input  logic [IDX_W-1:0]        read_row_i,
  input  logic [IDX_W-1:0]        read_col_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [PWR_W-1:0] read_value_o,
  output logic [ST_W-1:0]         status_o
);

  logic [BIN_W-1:0]        bin_width_q;
  logic signed [PWR_W-1:0] fill_value_q;
  cmd_t                    cmd;
  logic                    cmd_valid, cmd_pop;
  back_stat_t              back_stat;

  // Configuration registers accept a word every cycle; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q  <= BIN_W'(1);
      fill_value_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BIN_WIDTH:  bin_width_q  <= cfg_data_i[BIN_W-1:0];
        CFG_FILL_VALUE: fill_value_q <= cfg_data_i[PWR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each word as it enters the command queue.
  swr_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .freq_i         (freq_i),
    .power_i        (power_i),
    .first_of_row_i (first_of_row_i),
    .last_of_row_i  (last_of_row_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .bin_zero_i     (bin_width_q == '0),
    .back_i         (back_stat),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  // The back end owns the cell memory, the ring index and the row start.
  swr_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_width_i  (bin_width_q),
    .fill_value_i (fill_value_q),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .stat_o       (back_stat),
    .empty        (empty),
    .pop          (pop),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule
